@@ rtl/assert_macros.svh @@
// Assertion helpers for the checker in pbdf_checker.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBDF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PBDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

@@ rtl/pbdf_pkg.sv @@
`default_nettype none

package pbdf_pkg;

  // Character classes seen by the parser.
  typedef enum logic [2:0] {
    CLS_HEX,
    CLS_COLON,
    CLS_DOT,
    CLS_NUL,
    CLS_BAD
  } char_class_t;

  // Decoded character: its class and, for a hex digit, its value.
  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } char_info_t;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // Digit limits per field.
  localparam logic [2:0] FIRST_DIGITS_MAX = 3'd4;
  localparam logic [2:0] MID_DIGITS_MAX   = 3'd2;
  localparam logic [2:0] FUNC_DIGITS_MAX  = 3'd1;

  localparam logic [7:0] DEV_MAX  = 8'h1F;
  localparam logic [3:0] FUNC_MAX = 4'h7;

endpackage

`default_nettype wire

@@ rtl/pbdf_ifs.sv @@
`default_nettype none

// Character stream into the parser.
interface pbdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

// Parsed address out of the parser.
interface pbdf_out_if;
  logic        valid;
  logic        ready;
  logic        valid_res;
  logic [15:0] domain;
  logic [7:0]  bus;
  logic [4:0]  device;
  logic [2:0]  function_res;

  modport source (output valid, output valid_res, output domain, output bus,
                  output device, output function_res, input ready);
  modport sink   (input valid, input valid_res, input domain, input bus,
                  input device, input function_res, output ready);
endinterface

`default_nettype wire

@@ rtl/pci_bdf_string_parser_unit.sv @@
// PCI address string parser. Characters of a string of the form
// [domain:]bus:device.function arrive one per beat on in_ch, ended by a NUL
// byte; every field is case-insensitive hex, the domain taking one to four
// digits, the bus one or two, the device one or two with a value of at most
// 0x1F and the function exactly one digit from 0 to 7. Each NUL produces one
// beat on out_ch carrying valid_res and the four numbers, which are all zero
// when the string broke the grammar; the parser then starts afresh. One
// character is taken every clock cycle, and the result beat appears on out_ch
// in the cycle after its NUL is taken. The single output register is what
// sets the pace: the input only stalls while a result beat is held there and
// the sink is not taking it.
`default_nettype none

module pci_bdf_string_parser_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pbdf_in_if.sink    in_ch,
  pbdf_out_if.source out_ch
);

  // Which field the next digit belongs to.
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_FUNC
  } phase_t;

  pbdf_pkg::char_info_t info;

  phase_t      phase_r,        phase_nxt;
  logic [1:0]  colon_cnt_r,    colon_cnt_nxt;
  logic [2:0]  digit_cnt_r,    digit_cnt_nxt;
  logic [2:0]  first_digits_r, first_digits_nxt;
  logic [15:0] first_val_r,    first_val_nxt;
  logic [7:0]  second_val_r,   second_val_nxt;
  logic [7:0]  third_val_r,    third_val_nxt;
  logic [2:0]  func_val_r,     func_val_nxt;
  logic        err_r,          err_nxt;

  logic        out_valid_r,    out_valid_nxt;
  logic        res_ok_r,       res_ok_nxt;
  logic [15:0] res_dom_r,      res_dom_nxt;
  logic [7:0]  res_bus_r,      res_bus_nxt;
  logic [4:0]  res_dev_r,      res_dev_nxt;
  logic [2:0]  res_func_r,     res_func_nxt;

  logic        in_accept;
  logic [2:0]  digit_limit;

  // Working values for judging a finished string.
  logic        ok;
  logic [15:0] dom;
  logic [7:0]  bus;
  logic [7:0]  dev;

  pbdf_char_decode u_decode (
    .ch   (in_ch.character),
    .info (info)
  );

  // A new character is welcome unless a result beat is stuck in the output
  // register; a NUL would otherwise have nowhere to go.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  always_comb begin
    case (phase_r)
      PH_FIRST:  digit_limit = pbdf_pkg::FIRST_DIGITS_MAX;
      PH_SECOND: digit_limit = pbdf_pkg::MID_DIGITS_MAX;
      PH_THIRD:  digit_limit = pbdf_pkg::MID_DIGITS_MAX;
      PH_FUNC:   digit_limit = pbdf_pkg::FUNC_DIGITS_MAX;
      default:   digit_limit = pbdf_pkg::FUNC_DIGITS_MAX;
    endcase
  end

  // Judge the string as it stands, for use when the NUL arrives.
  always_comb begin
    ok  = !err_r && (phase_r == PH_FUNC) && (digit_cnt_r == 3'd1);
    dom = 16'd0;
    bus = 8'd0;
    dev = 8'd0;
    case (colon_cnt_r)
      2'd2: begin
        dom = first_val_r;
        bus = second_val_r;
        dev = third_val_r;
      end
      2'd1: begin
        // The leading field is the bus, so it may not exceed two digits.
        if (first_digits_r > pbdf_pkg::MID_DIGITS_MAX) ok = 1'b0;
        bus = first_val_r[7:0];
        dev = second_val_r;
      end
      default: ok = 1'b0;
    endcase
    if (dev > pbdf_pkg::DEV_MAX) ok = 1'b0;
  end

  always_comb begin
    phase_nxt        = phase_r;
    colon_cnt_nxt    = colon_cnt_r;
    digit_cnt_nxt    = digit_cnt_r;
    first_digits_nxt = first_digits_r;
    first_val_nxt    = first_val_r;
    second_val_nxt   = second_val_r;
    third_val_nxt    = third_val_r;
    func_val_nxt     = func_val_r;
    err_nxt          = err_r;

    res_ok_nxt   = res_ok_r;
    res_dom_nxt  = res_dom_r;
    res_bus_nxt  = res_bus_r;
    res_dev_nxt  = res_dev_r;
    res_func_nxt = res_func_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (in_accept) begin
      if (info.cls == pbdf_pkg::CLS_NUL) begin
        out_valid_nxt = 1'b1;
        res_ok_nxt    = ok;
        res_dom_nxt   = ok ? dom : 16'd0;
        res_bus_nxt   = ok ? bus : 8'd0;
        res_dev_nxt   = ok ? dev[4:0] : 5'd0;
        res_func_nxt  = ok ? func_val_r : 3'd0;

        phase_nxt        = PH_FIRST;
        colon_cnt_nxt    = 2'd0;
        digit_cnt_nxt    = 3'd0;
        first_digits_nxt = 3'd0;
        first_val_nxt    = 16'd0;
        second_val_nxt   = 8'd0;
        third_val_nxt    = 8'd0;
        func_val_nxt     = 3'd0;
        err_nxt          = 1'b0;
      end else if (!err_r) begin
        // Once the string is broken, everything up to the NUL is ignored.
        case (info.cls)
          pbdf_pkg::CLS_HEX: begin
            if (digit_cnt_r >= digit_limit) begin
              err_nxt = 1'b1;
            end else begin
              digit_cnt_nxt = digit_cnt_r + 3'd1;
              case (phase_r)
                PH_FIRST:  first_val_nxt  = {first_val_r[11:0], info.digit};
                PH_SECOND: second_val_nxt = {second_val_r[3:0], info.digit};
                PH_THIRD:  third_val_nxt  = {third_val_r[3:0], info.digit};
                PH_FUNC: begin
                  if (info.digit > pbdf_pkg::FUNC_MAX) err_nxt = 1'b1;
                  else func_val_nxt = info.digit[2:0];
                end
                default: err_nxt = 1'b1;
              endcase
            end
          end
          pbdf_pkg::CLS_COLON: begin
            if (digit_cnt_r == 3'd0 ||
                !(phase_r == PH_FIRST || phase_r == PH_SECOND)) begin
              err_nxt = 1'b1;
            end else begin
              if (phase_r == PH_FIRST) begin
                first_digits_nxt = digit_cnt_r;
                phase_nxt        = PH_SECOND;
              end else begin
                phase_nxt = PH_THIRD;
              end
              colon_cnt_nxt = colon_cnt_r + 2'd1;
              digit_cnt_nxt = 3'd0;
            end
          end
          pbdf_pkg::CLS_DOT: begin
            if (digit_cnt_r == 3'd0 || phase_r == PH_FIRST || phase_r == PH_FUNC) begin
              err_nxt = 1'b1;
            end else begin
              phase_nxt     = PH_FUNC;
              digit_cnt_nxt = 3'd0;
            end
          end
          default: err_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_FIRST;
      colon_cnt_r    <= 2'd0;
      digit_cnt_r    <= 3'd0;
      first_digits_r <= 3'd0;
      first_val_r    <= 16'd0;
      second_val_r   <= 8'd0;
      third_val_r    <= 8'd0;
      func_val_r     <= 3'd0;
      err_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      colon_cnt_r    <= colon_cnt_nxt;
      digit_cnt_r    <= digit_cnt_nxt;
      first_digits_r <= first_digits_nxt;
      first_val_r    <= first_val_nxt;
      second_val_r   <= second_val_nxt;
      third_val_r    <= third_val_nxt;
      func_val_r     <= func_val_nxt;
      err_r          <= err_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // The result payload needs no reset: it is only looked at under out_valid_r.
  always_ff @(posedge clk) begin
    res_ok_r   <= res_ok_nxt;
    res_dom_r  <= res_dom_nxt;
    res_bus_r  <= res_bus_nxt;
    res_dev_r  <= res_dev_nxt;
    res_func_r <= res_func_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.valid_res    = res_ok_r;
  assign out_ch.domain       = res_dom_r;
  assign out_ch.bus          = res_bus_r;
  assign out_ch.device       = res_dev_r;
  assign out_ch.function_res = res_func_r;

endmodule

`default_nettype wire

@@ rtl/pbdf_char_decode.sv @@
`default_nettype none

// Classifies one byte and extracts the hex digit value.
module pbdf_char_decode (
  input  wire logic [7:0]         ch,
  output pbdf_pkg::char_info_t    info
);

  always_comb begin
    info.cls   = pbdf_pkg::CLS_BAD;
    info.digit = 4'd0;
    case (ch) inside
      [8'h30:8'h39]: begin
        info.cls   = pbdf_pkg::CLS_HEX;
        info.digit = ch[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        // Letters a-f sit at 1..6 in the low nibble.
        info.cls   = pbdf_pkg::CLS_HEX;
        info.digit = ch[3:0] + 4'd9;
      end
      pbdf_pkg::CHAR_COLON: info.cls = pbdf_pkg::CLS_COLON;
      pbdf_pkg::CHAR_DOT:   info.cls = pbdf_pkg::CLS_DOT;
      pbdf_pkg::CHAR_NUL:   info.cls = pbdf_pkg::CLS_NUL;
      default:              info.cls = pbdf_pkg::CLS_BAD;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pbdf_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module pbdf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [7:0]  in_character,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_valid_res,
  input wire logic [15:0] out_domain,
  input wire logic [7:0]  out_bus,
  input wire logic [4:0]  out_device,
  input wire logic [2:0]  out_function_res
);

  logic        in_take;
  logic        nul_in;
  logic        out_stall;
  logic        res_zero;
  logic [32:0] out_payload;

  assign in_take     = in_valid && in_ready;
  assign nul_in      = (in_character == pbdf_pkg::CHAR_NUL);
  assign out_stall   = out_valid && !out_ready;
  assign res_zero    = (out_domain == 16'd0) && (out_bus == 8'd0) &&
                       (out_device == 5'd0) && (out_function_res == 3'd0);
  assign out_payload = {out_valid_res, out_domain, out_bus, out_device, out_function_res};

  // A rejected string carries only zeros.
  `PBDF_ASSERT_SAME(a_invalid_zero, out_valid && !out_valid_res, res_zero)

  // Every taken NUL shows up as a result beat in the next cycle.
  `PBDF_ASSERT_NEXT(a_nul_gives_beat, in_take && nul_in, out_valid)

  // Other characters never produce a result beat.
  `PBDF_ASSERT_NEXT(a_no_spurious_beat, in_take && !nul_in && !out_stall, !out_valid)

  // The input only stalls behind a held result beat.
  `PBDF_ASSERT_SAME(a_stall_cause, !in_ready, out_stall)

  // A stalled result beat holds its value.
  `PBDF_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload))

endmodule

bind pci_bdf_string_parser_unit pbdf_checker u_pbdf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_character     (in_ch.character),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_valid_res    (out_ch.valid_res),
  .out_domain       (out_ch.domain),
  .out_bus          (out_ch.bus),
  .out_device       (out_ch.device),
  .out_function_res (out_ch.function_res)
);

`default_nettype wire

@@ sim/pbdf_addr_checker.sv @@
`default_nettype none

// Watches both channels of the parser, keeps its own model of the parse
// state and compares every result beat with the oldest address awaited.
module pbdf_addr_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  pbdf_in_if        in_mon,
  pbdf_out_if       out_mon,
  output int        fail_count,
  output int        pending
);

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_FUNC
  } field_t;

  typedef struct packed {
    logic        valid_res;
    logic [15:0] domain;
    logic [7:0]  bus;
    logic [4:0]  device;
    logic [2:0]  function_res;
  } bdf_t;

  field_t     field;
  logic [1:0] colons;
  logic [2:0] digits;
  logic [2:0] lead_digits;
  logic [15:0] lead_val;
  logic [7:0]  mid_val;
  logic [7:0]  dev_val;
  logic [2:0]  fn_val;
  logic        broken;

  bdf_t addr_awaited[$];
  int   mismatches = 0;

  function automatic pbdf_pkg::char_info_t classify(input logic [7:0] ch);
    pbdf_pkg::char_info_t info;
    info.digit = 4'h0;
    info.cls   = pbdf_pkg::CLS_BAD;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      info.cls   = pbdf_pkg::CLS_HEX;
      info.digit = ch[3:0];
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      // Letters a to f sit at offsets 1 to 6 in both cases.
      info.cls   = pbdf_pkg::CLS_HEX;
      info.digit = ch[3:0] + 4'd9;
    end else if (ch == pbdf_pkg::CHAR_COLON) begin
      info.cls = pbdf_pkg::CLS_COLON;
    end else if (ch == pbdf_pkg::CHAR_DOT) begin
      info.cls = pbdf_pkg::CLS_DOT;
    end else if (ch == pbdf_pkg::CHAR_NUL) begin
      info.cls = pbdf_pkg::CLS_NUL;
    end
    return info;
  endfunction

  task automatic clear_parse();
    field       = PH_FIRST;
    colons      = 2'd0;
    digits      = 3'd0;
    lead_digits = 3'd0;
    lead_val    = 16'h0;
    mid_val     = 8'h0;
    dev_val     = 8'h0;
    fn_val      = 3'd0;
    broken      = 1'b0;
  endtask

  function automatic bdf_t resolve_address();
    bdf_t        r;
    logic        ok;
    logic [15:0] dom;
    logic [7:0]  bus;
    logic [7:0]  dev;
    ok  = !broken && field == PH_FUNC && digits == 3'd1;
    dom = 16'h0;
    bus = 8'h0;
    dev = 8'h0;
    if (ok && colons == 2'd2) begin
      dom = lead_val;
      bus = mid_val;
      dev = dev_val;
    end else if (ok && colons == 2'd1) begin
      // In the short form the leading field is the bus, so it must fit a byte.
      if (lead_digits > pbdf_pkg::MID_DIGITS_MAX) ok = 1'b0;
      bus = lead_val[7:0];
      dev = mid_val;
    end else begin
      ok = 1'b0;
    end
    if (dev > pbdf_pkg::DEV_MAX) ok = 1'b0;
    r.valid_res    = ok;
    r.domain       = ok ? dom : 16'h0;
    r.bus          = ok ? bus : 8'h0;
    r.device       = ok ? dev[4:0] : 5'h0;
    r.function_res = ok ? fn_val : 3'd0;
    return r;
  endfunction

  task automatic absorb_char(input logic [7:0] ch);
    pbdf_pkg::char_info_t info;
    logic [2:0] limit;
    info = classify(ch);
    if (info.cls == pbdf_pkg::CLS_NUL) begin
      addr_awaited.push_back(resolve_address());
      clear_parse();
    end else if (!broken) begin
      case (info.cls)
        pbdf_pkg::CLS_HEX: begin
          case (field)
            PH_FIRST: limit = pbdf_pkg::FIRST_DIGITS_MAX;
            PH_FUNC:  limit = pbdf_pkg::FUNC_DIGITS_MAX;
            default:  limit = pbdf_pkg::MID_DIGITS_MAX;
          endcase
          if (digits >= limit) begin
            broken = 1'b1;
          end else begin
            digits = digits + 3'd1;
            case (field)
              PH_FIRST:  lead_val = {lead_val[11:0], info.digit};
              PH_SECOND: mid_val  = {mid_val[3:0], info.digit};
              PH_THIRD:  dev_val  = {dev_val[3:0], info.digit};
              default: begin
                if (info.digit > pbdf_pkg::FUNC_MAX) broken = 1'b1;
                else fn_val = info.digit[2:0];
              end
            endcase
          end
        end
        pbdf_pkg::CLS_COLON: begin
          if (digits == 3'd0 || field > PH_SECOND) begin
            broken = 1'b1;
          end else begin
            if (field == PH_FIRST) lead_digits = digits;
            field  = field_t'(field + 2'd1);
            colons = colons + 2'd1;
            digits = 3'd0;
          end
        end
        pbdf_pkg::CLS_DOT: begin
          if (digits == 3'd0 || field == PH_FIRST || field == PH_FUNC) begin
            broken = 1'b1;
          end else begin
            field  = PH_FUNC;
            digits = 3'd0;
          end
        end
        default: broken = 1'b1;
      endcase
    end
  endtask

  task automatic report_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    bdf_t want;
    if (!rst_n) begin
      clear_parse();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (addr_awaited.size() == 0) begin
          $display("%0t: result beat expected none got valid_res=%b %h:%h:%h.%h", $time,
                   out_mon.valid_res, out_mon.domain, out_mon.bus, out_mon.device,
                   out_mon.function_res);
          mismatches++;
        end else begin
          want = addr_awaited.pop_front();
          report_field("valid_res", 16'(want.valid_res), 16'(out_mon.valid_res));
          report_field("domain", want.domain, out_mon.domain);
          report_field("bus", 16'(want.bus), 16'(out_mon.bus));
          report_field("device", 16'(want.device), 16'(out_mon.device));
          report_field("function_res", 16'(want.function_res),
                       16'(out_mon.function_res));
        end
      end
      if (in_mon.valid && in_mon.ready) absorb_char(in_mon.character);
    end
    fail_count <= mismatches;
    pending    <= addr_awaited.size();
  end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none

// Top of the parser testbench. It only makes stimulus and reaches the
// verdict; the checker beside the block does all prediction and comparison.
module tb;

  logic clk = 1'b0;
  logic rst_n;

  // Free-running clock with a period of twenty units.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  pbdf_in_if  in_ch ();
  pbdf_out_if out_ch ();

  int fail_count;
  int pending;

  pci_bdf_string_parser_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pbdf_addr_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Characters of the string now being sent, NUL included.
  logic [7:0] str_buf[$];
  int         chars_sent = 0;
  bit         calm;

  // Gap lengths: mostly none or short, now and then a long one. A calm
  // stretch gives back-to-back beats so that the fast path is covered too.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // A hex digit, with letters in a case picked at random.
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
  endfunction

  task automatic push_hex(input int nd, input logic [19:0] val);
    for (int i = nd - 1; i >= 0; i--) begin
      str_buf.push_back(hex_char(val[4*i +: 4]));
    end
  endtask

  task automatic load_text(input string s);
    str_buf.delete();
    foreach (s[i]) str_buf.push_back(s[i]);
    str_buf.push_back(pbdf_pkg::CHAR_NUL);
  endtask

  // A well-formed address with random content. Some field widths and values
  // are deliberately pushed past their limits so that the checks on digit
  // counts, a long bus in the short form, a large device and a large function
  // all get reached with the rest of the string still intact.
  task automatic build_address();
    int          nd;
    logic [19:0] val;
    str_buf.delete();
    if ($urandom_range(0, 1)) begin
      nd = ($urandom_range(0, 11) == 0) ? 5 : $urandom_range(1, 4);
      push_hex(nd, 20'($urandom));
      str_buf.push_back(pbdf_pkg::CHAR_COLON);
    end
    nd = ($urandom_range(0, 7) == 0) ? 3 : $urandom_range(1, 2);
    push_hex(nd, 20'($urandom));
    str_buf.push_back(pbdf_pkg::CHAR_COLON);
    val = 20'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                          : $urandom_range(0, 31));
    nd  = (val > 15) ? 2 : $urandom_range(1, 2);
    if ($urandom_range(0, 15) == 0) nd = 3;
    push_hex(nd, val);
    str_buf.push_back(pbdf_pkg::CHAR_DOT);
    val = 20'(($urandom_range(0, 5) == 0) ? $urandom_range(8, 15)
                                          : $urandom_range(0, 7));
    nd  = ($urandom_range(0, 15) == 0) ? 2 : 1;
    push_hex(nd, val);
  endtask

  // Breaks an address in one of several ways: a stray byte, a lost
  // character, an extra digit or separator, or an early end.
  task automatic mutate_address();
    int pos;
    pos = $urandom_range(0, str_buf.size() - 1);
    case ($urandom_range(0, 6))
      0: str_buf[pos] = 8'($urandom_range(1, 255));
      1: str_buf.insert(pos, 8'($urandom_range(1, 255)));
      2: str_buf.delete(pos);
      3: str_buf.insert(pos, hex_char(4'($urandom)));
      4: str_buf.insert(pos, pbdf_pkg::CHAR_COLON);
      5: str_buf.insert(pos, pbdf_pkg::CHAR_DOT);
      default: begin
        while (str_buf.size() > pos) void'(str_buf.pop_back());
      end
    endcase
  endtask

  // Short runs of noise, leaning on the characters the grammar knows.
  task automatic build_noise();
    int len;
    str_buf.delete();
    len = $urandom_range(0, 10);
    repeat (len) begin
      case ($urandom_range(0, 3))
        0:       str_buf.push_back(8'($urandom_range(1, 255)));
        1:       str_buf.push_back(pbdf_pkg::CHAR_COLON);
        2:       str_buf.push_back(pbdf_pkg::CHAR_DOT);
        default: str_buf.push_back(hex_char(4'($urandom)));
      endcase
    end
  endtask

  // Offers one character and holds it until the parser takes the beat.
  // Valid is only lowered when a real gap follows, so a beat that follows
  // straight on never sees valid dropped and raised in the same step.
  task automatic send_char(input logic [7:0] ch);
    int gap;
    gap = pick_gap(calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.character <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_string();
    calm = ($urandom_range(0, 4) == 0);
    foreach (str_buf[i]) send_char(str_buf[i]);
  endtask

  // Sender side: reset, a few directed strings, then random traffic.
  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.character <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Largest values in every field with mixed case, the smallest short
    // form, a device just out of range and a string that is nothing but NUL.
    load_text("ffFF:Ff:1F.7");
    send_string();
    load_text("0:0.0");
    send_string();
    load_text("1:20.0");
    send_string();
    load_text("");
    send_string();

    // Mostly addresses with random content, a share of them broken, and the
    // rest plain noise; each string is closed by its NUL.
    while (chars_sent < 1680) begin
      if ($urandom_range(0, 9) == 0) begin
        build_noise();
      end else begin
        build_address();
        if ($urandom_range(0, 3) == 0) mutate_address();
      end
      str_buf.push_back(pbdf_pkg::CHAR_NUL);
      send_string();
    end
    in_ch.valid <= 1'b0;

    // Let the checker see the last beat, drain what is still awaited, then
    // leave a short tail for any stray result beat to show itself.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Receiver side: runs of ready with random gaps. Once, early on, it holds
  // off while the sender keeps offering, so that a result beat sits in the
  // output register and the input backs up.
  initial begin
    bit held_off;
    int gap;
    held_off     = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held_off && chars_sent >= 300) begin
        held_off = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        gap = pick_gap(1'b0);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
